@@ design/sdci_pkg.sv @@
// Shared types and constants for the SD card initialization sequencer.
// Holds the sequencer phase encoding, result and response codes, command
// indexes and the CSD decode constants. No dependencies.
package sdci_pkg;

  localparam int CAP_W       = 32;
  localparam int BLOCK_BYTES = 512;
  localparam int BLOCK_SHIFT = $clog2(BLOCK_BYTES);
  // CSD v2 counts capacity in 512 KiB units
  localparam int V2_SHIFT    = 19 - BLOCK_SHIFT;

  localparam logic [9:0] RETRY_LIMIT_RST = 10'd100;

  localparam logic [31:0] CMD8_ARG    = 32'h0000_01AA;
  localparam logic [31:0] ACMD41_ARG  = 32'h00FF_8000;
  localparam logic [31:0] ACMD6_ARG   = 32'h0000_0002;
  localparam logic [3:0]  V2_BL_LEN   = 4'd9;

  localparam logic [5:0] CMD_GO_IDLE   = 6'd0;
  localparam logic [5:0] CMD_SEND_IF   = 6'd8;
  localparam logic [5:0] CMD_APP       = 6'd55;
  localparam logic [5:0] CMD_OP_COND   = 6'd41;
  localparam logic [5:0] CMD_ALL_CID   = 6'd2;
  localparam logic [5:0] CMD_SEND_RCA  = 6'd3;
  localparam logic [5:0] CMD_READ_CSD  = 6'd9;
  localparam logic [5:0] CMD_SELECT    = 6'd7;
  localparam logic [5:0] CMD_BUS_WIDTH = 6'd6;

  localparam logic OP_START = 1'b0;
  localparam logic OP_DONE  = 1'b1;

  localparam logic [1:0] KIND_CMD  = 2'd0;
  localparam logic [1:0] KIND_OK   = 2'd1;
  localparam logic [1:0] KIND_FAIL = 2'd2;

  localparam logic [1:0] RSP_NONE  = 2'd0;
  localparam logic [1:0] RSP_SHORT = 2'd1;
  localparam logic [1:0] RSP_LONG  = 2'd2;

  localparam logic [2:0] ADDR_RETRY_LIMIT = 3'd0;

  typedef enum logic [13:0] {
    PH_IDLE   = 14'b00_0000_0000_0001,
    PH_INIT   = 14'b00_0000_0000_0010,
    PH_CMD0   = 14'b00_0000_0000_0100,
    PH_CMD8   = 14'b00_0000_0000_1000,
    PH_CMD55  = 14'b00_0000_0001_0000,
    PH_ACMD41 = 14'b00_0000_0010_0000,
    PH_CMD2   = 14'b00_0000_0100_0000,
    PH_CMD3   = 14'b00_0000_1000_0000,
    PH_CMD9   = 14'b00_0001_0000_0000,
    PH_CMD7   = 14'b00_0010_0000_0000,
    PH_APP    = 14'b00_0100_0000_0000,
    PH_ACMD6  = 14'b00_1000_0000_0000,
    PH_DONE   = 14'b01_0000_0000_0000,
    PH_FAILED = 14'b10_0000_0000_0000
  } phase_t;

endpackage

@@ design/sd_card_init_sequencer.sv @@
// SD card initialization sequencer, top level.
// Depends on sdci_pkg for phase encoding, codes and CSD constants.
//
// Host-side SD bring-up: a start word requests the init clock sequence, each
// command-done word yields the next command (CMD0, CMD8, CMD55/ACMD41 poll,
// CMD2, CMD3, CMD9 with CSD capacity decode, CMD7, CMD55, ACMD6) and finally a
// success or failure word. An accepted word is held in the input register and
// the next-step logic loads the result register from it when that register
// is free or being read; one word can be accepted in every cycle, and the only
// stall comes from result_ready holding the result register. Capacity,
// high_capacity and card_address show the current saved card state and are
// final in the success word. Registers: retry_limit at byte address 0,
// host_capacity_support at byte address 4.
module sd_card_init_sequencer (
  input  logic        clk,
  input  logic        rst,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // item channel
  input  logic        item_valid,
  output logic        item_ready,
  input  logic        opcode,
  input  logic        cmd_error,
  input  logic [31:0] resp_word0,
  input  logic [31:0] resp_word1,
  input  logic [31:0] resp_word2,
  input  logic [31:0] resp_word3,
  // result channel
  output logic        result_valid,
  input  logic        result_ready,
  output logic [1:0]  kind,
  output logic [5:0]  cmd_index,
  output logic [31:0] cmd_argument,
  output logic [1:0]  response_kind,
  output logic        init_clocks,
  output logic        delay_before,
  output logic        fast_clock,
  output logic [sdci_pkg::CAP_W-1:0] capacity_blocks,
  output logic        high_capacity,
  output logic [15:0] card_address
);
  import sdci_pkg::*;

  // configuration
  logic [9:0] retry_limit;
  logic       host_capacity_support;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      retry_limit           <= RETRY_LIMIT_RST;
      host_capacity_support <= 1'b1;
    end else if (cfg_wr) begin
      if (paddr[2]) begin
        host_capacity_support <= pwdata[0];
      end else begin
        retry_limit <= pwdata[9:0];
      end
    end
  end

  always_comb begin
    if (paddr[2]) begin
      prdata = {31'd0, host_capacity_support};
    end else begin
      prdata = {22'd0, retry_limit};
    end
  end

  // input register
  logic        s1_valid;
  logic        s1_op;
  logic        s1_err;
  logic [31:0] s1_w0;
  logic [31:0] s1_w1;
  logic [31:0] s1_w2;
  logic        adv;
  logic        item_acc;

  assign adv        = s1_valid && (!result_valid || result_ready);
  assign item_ready = !s1_valid || adv;
  assign item_acc   = item_valid && item_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item_ready) begin
      s1_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_acc) begin
      s1_op  <= opcode;
      s1_err <= cmd_error;
      s1_w0  <= resp_word0;
      s1_w1  <= resp_word1;
      s1_w2  <= resp_word2;
    end
  end

  // state
  phase_t      phase, phase_next;
  logic [9:0]  retry_count, retry_count_next;
  logic [15:0] saved_address, saved_address_next;
  logic        saved_high_capacity, saved_high_capacity_next;
  logic [CAP_W-1:0] saved_capacity, saved_capacity_next;

  // CSD decode
  logic [3:0]  bl_len;
  logic [22:0] v2_sum;
  logic [32:0] v2_blocks;
  logic [CAP_W-1:0] v2_cap;
  logic        v2_bad;
  logic [12:0] v1_sum;
  logic [4:0]  v1_shift;
  logic [47:0] v1_total;
  logic [CAP_W-1:0] v1_cap;
  logic [CAP_W-1:0] csd_cap;

  always_comb begin
    bl_len    = s1_w1[19:16];
    v2_bad    = bl_len != V2_BL_LEN;
    v2_sum    = {1'b0, s1_w1[5:0], s1_w2[31:16]} + 23'd1;
    v2_blocks = {10'd0, v2_sum} << V2_SHIFT;
    v2_cap    = v2_blocks[32] ? '1 : v2_blocks[CAP_W-1:0];
    v1_sum    = {1'b0, s1_w1[9:0], s1_w2[31:30]} + 13'd1;
    v1_shift  = 5'(s1_w2[17:15]) + 5'd2 + 5'(bl_len) - 5'(BLOCK_SHIFT);
    v1_total  = {35'd0, v1_sum} << v1_shift;
    if (bl_len < 4'(BLOCK_SHIFT)) begin
      v1_cap = '0;
    end else if (|v1_total[47:CAP_W]) begin
      v1_cap = '1;
    end else begin
      v1_cap = v1_total[CAP_W-1:0];
    end
    csd_cap = s1_w0[30] ? v2_cap : v1_cap;
  end

  // next-step logic
  logic        r_has;
  logic [1:0]  r_kind;
  logic [5:0]  r_idx;
  logic [31:0] r_arg;
  logic [1:0]  r_rk;
  logic        r_init;
  logic        r_dly;
  logic        r_fast;
  logic [9:0]  retry_inc;
  logic [9:0]  limit_eff;

  assign retry_inc = retry_count + 10'd1;
  assign limit_eff = (retry_limit == 10'd0) ? 10'd1 : retry_limit;

  always_comb begin
    phase_next               = phase;
    retry_count_next         = retry_count;
    saved_address_next       = saved_address;
    saved_high_capacity_next = saved_high_capacity;
    saved_capacity_next      = saved_capacity;
    r_has  = 1'b1;
    r_kind = KIND_CMD;
    r_idx  = CMD_GO_IDLE;
    r_arg  = '0;
    r_rk   = RSP_NONE;
    r_init = 1'b0;
    r_dly  = 1'b0;
    r_fast = 1'b0;
    if (s1_op == OP_START) begin
      retry_count_next         = '0;
      saved_address_next       = '0;
      saved_high_capacity_next = 1'b0;
      saved_capacity_next      = '0;
      phase_next               = PH_INIT;
      r_init                   = 1'b1;
    end else begin
      unique case (phase)
        PH_INIT: begin
          phase_next = PH_CMD0;
        end
        PH_CMD0: begin
          phase_next = PH_CMD8;
          r_idx      = CMD_SEND_IF;
          r_arg      = CMD8_ARG;
          r_rk       = RSP_SHORT;
        end
        PH_CMD8: begin
          retry_count_next = '0;
          phase_next       = PH_CMD55;
          r_idx            = CMD_APP;
          r_rk             = RSP_SHORT;
          r_dly            = 1'b1;
        end
        PH_CMD55: begin
          if (s1_err) begin
            phase_next = PH_FAILED;
            r_kind     = KIND_FAIL;
          end else begin
            phase_next = PH_ACMD41;
            r_idx      = CMD_OP_COND;
            r_arg      = ACMD41_ARG | {1'b0, host_capacity_support, 30'd0};
            r_rk       = RSP_SHORT;
          end
        end
        PH_ACMD41: begin
          if (s1_err) begin
            phase_next = PH_FAILED;
            r_kind     = KIND_FAIL;
          end else if (s1_w0[31]) begin
            saved_high_capacity_next = s1_w0[30];
            phase_next               = PH_CMD2;
            r_idx                    = CMD_ALL_CID;
            r_rk                     = RSP_LONG;
          end else begin
            retry_count_next = retry_inc;
            if (retry_inc >= limit_eff) begin
              phase_next = PH_FAILED;
              r_kind     = KIND_FAIL;
            end else begin
              phase_next = PH_CMD55;
              r_idx      = CMD_APP;
              r_rk       = RSP_SHORT;
              r_dly      = 1'b1;
            end
          end
        end
        PH_CMD2: begin
          phase_next = PH_CMD3;
          r_idx      = CMD_SEND_RCA;
          r_rk       = RSP_SHORT;
        end
        PH_CMD3: begin
          saved_address_next = s1_w0[31:16];
          phase_next         = PH_CMD9;
          r_idx              = CMD_READ_CSD;
          r_arg              = {s1_w0[31:16], 16'd0};
          r_rk               = RSP_LONG;
        end
        PH_CMD9: begin
          if (s1_w0[30] && v2_bad) begin
            phase_next = PH_FAILED;
            r_kind     = KIND_FAIL;
          end else begin
            saved_capacity_next = csd_cap;
            phase_next          = PH_CMD7;
            r_idx               = CMD_SELECT;
            r_arg               = {saved_address, 16'd0};
            r_rk                = RSP_SHORT;
            r_fast              = 1'b1;
          end
        end
        PH_CMD7: begin
          phase_next = PH_APP;
          r_idx      = CMD_APP;
          r_arg      = {saved_address, 16'd0};
          r_rk       = RSP_SHORT;
        end
        PH_APP: begin
          phase_next = PH_ACMD6;
          r_idx      = CMD_BUS_WIDTH;
          r_arg      = ACMD6_ARG;
          r_rk       = RSP_SHORT;
        end
        PH_ACMD6: begin
          phase_next = PH_DONE;
          r_kind     = KIND_OK;
        end
        default: begin
          r_has = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase               <= PH_IDLE;
      retry_count         <= '0;
      saved_address       <= '0;
      saved_high_capacity <= 1'b0;
      saved_capacity      <= '0;
    end else if (adv) begin
      phase               <= phase_next;
      retry_count         <= retry_count_next;
      saved_address       <= saved_address_next;
      saved_high_capacity <= saved_high_capacity_next;
      saved_capacity      <= saved_capacity_next;
    end
  end

  // result register; saved state only moves when this register is free
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (adv) begin
      result_valid <= r_has;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      kind          <= r_kind;
      cmd_index     <= r_idx;
      cmd_argument  <= r_arg;
      response_kind <= r_rk;
      init_clocks   <= r_init;
      delay_before  <= r_dly;
      fast_clock    <= r_fast;
    end
  end

  assign capacity_blocks = saved_capacity;
  assign high_capacity   = saved_high_capacity;
  assign card_address    = saved_address;

`ifndef ASSERT_OFF
  a_held_word_kept: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !adv |=> s1_valid)
    else $error("input word dropped while stalled");

  a_ok_done: assert property (@(posedge clk) disable iff (rst)
    result_valid && kind == KIND_OK |-> phase == PH_DONE)
    else $error("success word outside done phase");

  a_fail_phase: assert property (@(posedge clk) disable iff (rst)
    result_valid && kind == KIND_FAIL |-> phase == PH_FAILED)
    else $error("failure word outside failed phase");

  a_init_clear: assert property (@(posedge clk) disable iff (rst)
    result_valid && init_clocks |-> phase == PH_INIT && saved_capacity == '0
      && saved_address == '0 && retry_count == '0)
    else $error("init request with stale card state");

  a_fast_select: assert property (@(posedge clk) disable iff (rst)
    result_valid && fast_clock |-> cmd_index == CMD_SELECT && phase == PH_CMD7)
    else $error("fast clock on a command other than select");
`endif

endmodule
